// ===== hw/rtl/risc_instruction_execute_assert.svh =====
// Assertion macros used by the execute unit RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef RISC_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RISC_INSTRUCTION_EXECUTE_ASSERT_SVH

// same-cycle implication
`define RIE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RIE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rie_pkg.sv =====
// Types, constants and helpers for the RISC instruction execute unit.
// No dependencies; imported by every module of the block.
package rie_pkg;

    localparam int DATA_W           = 32;
    localparam int WORD_W           = 20;
    localparam int PC_W             = 12;
    localparam int REG_COUNT        = 16;
    localparam int REG_AW           = $clog2(REG_COUNT);
    localparam int MEM_DEPTH        = 4096;
    localparam int MEM_AW           = $clog2(MEM_DEPTH);
    localparam int IO_COUNT         = 32;
    localparam int IO_AW            = $clog2(IO_COUNT);
    localparam int IRQ_RETURN_INDEX = 7;
    localparam int IRQ_SLOT         = IRQ_RETURN_INDEX % IO_COUNT;
    localparam int MEM_ADDR_W       = 12;
    localparam int IO_NUM_W         = 5;

    localparam logic [REG_AW-1:0] REG_ZERO  = REG_AW'(0);
    localparam logic [REG_AW-1:0] REG_IMM   = REG_AW'(1);
    localparam logic [REG_AW-1:0] FIRST_GPR = REG_AW'(2);

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_AND  = 5'd3,
        OP_OR   = 5'd4,
        OP_XOR  = 5'd5,
        OP_SLL  = 5'd6,
        OP_SRA  = 5'd7,
        OP_SRL  = 5'd8,
        OP_BEQ  = 5'd9,
        OP_BNE  = 5'd10,
        OP_BLT  = 5'd11,
        OP_BGT  = 5'd12,
        OP_BLE  = 5'd13,
        OP_BGE  = 5'd14,
        OP_JAL  = 5'd15,
        OP_LW   = 5'd16,
        OP_SW   = 5'd17,
        OP_RETI = 5'd18,
        OP_IN   = 5'd19,
        OP_OUT  = 5'd20,
        OP_HALT = 5'd21
    } opcode_t;

    typedef struct packed {
        logic [4:0]              op;
        logic [REG_AW-1:0]       dest_index;
        logic [REG_AW-1:0]       src_a_index;
        logic [REG_AW-1:0]       src_b_index;
        logic signed [WORD_W-1:0] immediate;
        logic                    has_immediate;
    } in_item_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic                     reg_written;
        logic [REG_AW-1:0]        reg_number;
        logic signed [DATA_W-1:0] reg_value;
        logic                     mem_written;
        logic [MEM_ADDR_W-1:0]    mem_address;
        logic                     io_written;
        logic [IO_NUM_W-1:0]      io_number;
        logic signed [DATA_W-1:0] io_value;
        logic                     halted;
        logic                     bad_opcode;
    } out_item_t;

    // side effects of one instruction, beyond what the result beat reports
    typedef struct packed {
        logic              load;
        logic              store;
        logic [MEM_AW-1:0] mem_addr;
        logic [WORD_W-1:0] mem_wdata;
        logic [IO_AW-1:0]  io_idx;
    } exec_ctl_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } dmem_req_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] num;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    function automatic logic [DATA_W-1:0] sext_word(input logic [WORD_W-1:0] w);
        return {{(DATA_W - WORD_W){w[WORD_W-1]}}, w};
    endfunction

endpackage

// ===== hw/rtl/rie_regfile.sv =====
// General register file: two banks written together, read with registered data.
// Depends on rie_pkg. Entries never written read as zero through valid bits.
module rie_regfile import rie_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [REG_AW-1:0] rs_addr,
    input  logic [REG_AW-1:0] rt_addr,
    input  logic [REG_AW-1:0] rd_addr,
    input  rf_wr_t            wr,
    output logic [DATA_W-1:0] rs_data,
    output logic [DATA_W-1:0] rt_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0]    bank_a_mem [REG_COUNT];
    logic [DATA_W-1:0]    bank_b_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0]    rs_q_reg, rt_q_reg, rd_q_reg;
    logic                 rs_v_reg, rt_v_reg, rd_v_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            bank_a_mem[wr.num] <= wr.data;
            bank_b_mem[wr.num] <= wr.data;
        end
        if (rd_en) begin
            rs_q_reg <= bank_a_mem[rs_addr];
            rt_q_reg <= bank_a_mem[rt_addr];
            rd_q_reg <= bank_b_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rs_v_reg  <= 1'b0;
            rt_v_reg  <= 1'b0;
            rd_v_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.num] <= 1'b1;
            end
            if (rd_en) begin
                rs_v_reg <= valid_reg[rs_addr];
                rt_v_reg <= valid_reg[rt_addr];
                rd_v_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rs_data = rs_v_reg ? rs_q_reg : '0;
    assign rt_data = rt_v_reg ? rt_q_reg : '0;
    assign rd_data = rd_v_reg ? rd_q_reg : '0;

endmodule

// ===== hw/rtl/rie_dmem.sv =====
// Data memory, one word per address, single port with registered read.
// Depends on rie_pkg. Swept to zero once after reset; busy is high meanwhile.
module rie_dmem import rie_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dmem_req_t         req,
    output logic [WORD_W-1:0] rdata,
    output logic              busy
);

    logic [WORD_W-1:0] store_mem [MEM_DEPTH];
    logic [MEM_AW-1:0] clr_addr_reg;
    logic              clearing_reg;
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + MEM_AW'(1);
            if (clr_addr_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            store_mem[clr_addr_reg] <= '0;
        end else if (req.we) begin
            store_mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= store_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

// ===== hw/rtl/rie_exec.sv =====
// Execute logic for one instruction: ALU, shifts, branches, jal, memory and I/O decode.
// Depends on rie_pkg. Purely combinational; operands arrive already forwarded.
module rie_exec import rie_pkg::*; (
    input  in_item_t                         item,
    input  logic [DATA_W-1:0]                a,
    input  logic [DATA_W-1:0]                b,
    input  logic [DATA_W-1:0]                d,
    input  logic [PC_W-1:0]                  pc,
    input  logic                             halted_in,
    input  logic [IO_COUNT-1:0][DATA_W-1:0]  io_regs,
    output out_item_t                        result,
    output exec_ctl_t                        ctl
);

    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] val;
    logic [4:0]        sh;
    logic [PC_W-1:0]   npc_seq;
    logic [PC_W-1:0]   npc;
    logic [IO_AW-1:0]  io_idx;
    logic              wr;
    logic              halt_set;
    logic              bad;

    assign sum     = a + b;
    assign sh      = b[4:0];
    assign io_idx  = sum[IO_AW-1:0];
    assign npc_seq = pc + PC_W'(1) + PC_W'(item.has_immediate);

    always_comb begin
        result   = '0;
        ctl      = '0;
        val      = '0;
        wr       = 1'b0;
        npc      = npc_seq;
        halt_set = 1'b0;
        bad      = 1'b0;

        case (item.op)
            OP_ADD: begin
                val = sum;
                wr  = 1'b1;
            end
            OP_SUB: begin
                val = a - b;
                wr  = 1'b1;
            end
            OP_MUL: begin
                val = a * b;
                wr  = 1'b1;
            end
            OP_AND: begin
                val = a & b;
                wr  = 1'b1;
            end
            OP_OR: begin
                val = a | b;
                wr  = 1'b1;
            end
            OP_XOR: begin
                val = a ^ b;
                wr  = 1'b1;
            end
            OP_SLL: begin
                val = a << sh;
                wr  = 1'b1;
            end
            OP_SRA: begin
                val = $unsigned($signed(a) >>> sh);
                wr  = 1'b1;
            end
            OP_SRL: begin
                val = a >> sh;
                wr  = 1'b1;
            end
            OP_BEQ: begin
                if (a == b) npc = d[PC_W-1:0];
            end
            OP_BNE: begin
                if (a != b) npc = d[PC_W-1:0];
            end
            OP_BLT: begin
                if ($signed(a) < $signed(b)) npc = d[PC_W-1:0];
            end
            OP_BGT: begin
                if ($signed(b) < $signed(a)) npc = d[PC_W-1:0];
            end
            OP_BLE: begin
                if (!($signed(b) < $signed(a))) npc = d[PC_W-1:0];
            end
            OP_BGE: begin
                if (!($signed(a) < $signed(b))) npc = d[PC_W-1:0];
            end
            OP_JAL: begin
                // link gets the advanced pc; target uses rs as read before the write
                val = DATA_W'(npc_seq);
                wr  = 1'b1;
                npc = a[PC_W-1:0];
            end
            OP_LW: begin
                // loaded word is merged in after the memory read
                ctl.load           = 1'b1;
                ctl.mem_addr       = sum[MEM_AW-1:0];
                result.mem_address = MEM_ADDR_W'(sum[MEM_AW-1:0]);
                wr                 = 1'b1;
            end
            OP_SW: begin
                ctl.store          = 1'b1;
                ctl.mem_addr       = sum[MEM_AW-1:0];
                ctl.mem_wdata      = d[WORD_W-1:0];
                result.mem_written = 1'b1;
                result.mem_address = MEM_ADDR_W'(sum[MEM_AW-1:0]);
            end
            OP_RETI: begin
                npc = io_regs[IRQ_SLOT][PC_W-1:0];
            end
            OP_IN: begin
                ctl.io_idx       = io_idx;
                result.io_number = IO_NUM_W'(io_idx);
                result.io_value  = io_regs[io_idx];
                val              = io_regs[io_idx];
                wr               = 1'b1;
            end
            OP_OUT: begin
                ctl.io_idx        = io_idx;
                result.io_number  = IO_NUM_W'(io_idx);
                result.io_value   = d;
                result.io_written = 1'b1;
            end
            OP_HALT: begin
                npc      = pc;
                halt_set = 1'b1;
            end
            default: begin
                npc      = pc;
                halt_set = 1'b1;
                bad      = 1'b1;
            end
        endcase

        result.next_pc = npc;
        if (wr && item.dest_index >= FIRST_GPR) begin
            result.reg_written = 1'b1;
            result.reg_number  = item.dest_index;
            result.reg_value   = ctl.load ? '0 : val;
        end
        result.halted     = halt_set;
        result.bad_opcode = bad;

        // once halted, every beat just reports the held pc
        if (halted_in) begin
            result         = '0;
            ctl            = '0;
            result.next_pc = pc;
            result.halted  = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/risc_instruction_execute.sv =====
// Execute unit of a small RISC core. One decoded instruction per s_ beat, one result
// per m_ beat. Sustained rate is one instruction per clock while m_ready stays high
// and no memory sweep runs; a result reaches m_ through the input register, then the
// result register. While a result waits for m_ready, one more beat can be taken into
// the input register, then s_ready drops until m_ready returns. Operand read, ALU or
// 32x32 multiply, branch resolve and state update all sit between those two registers;
// register-file and load results are forwarded, so dependent instructions never stall.
// After reset the 4096-word data memory is swept to zero, one word a clock, and s_ready
// stays low until the sweep ends. Depends on rie_pkg, rie_regfile, rie_dmem, rie_exec.
module risc_instruction_execute import rie_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

`include "risc_instruction_execute_assert.svh"

    typedef struct packed {
        logic              wr;
        logic [REG_AW-1:0] num;
        logic [DATA_W-1:0] val;
        logic              load;
    } wb_info_t;

    logic                            s1_valid_reg;
    in_item_t                        s1_item_reg;
    logic                            m_valid_reg;
    out_item_t                       out_reg;
    logic                            out_load_reg;
    logic [PC_W-1:0]                 pc_reg;
    logic                            halt_reg;
    logic [IO_COUNT-1:0][DATA_W-1:0] io_reg;
    wb_info_t                        last_wr_reg;
    logic                            wb_pending_reg;
    logic                            cap_valid_reg;
    logic [REG_AW-1:0]               cap_num_reg;
    logic [DATA_W-1:0]               cap_val_reg;

    logic              accept;
    logic              s1_adv;
    logic              dm_busy;
    logic [WORD_W-1:0] dm_rdata;
    logic [DATA_W-1:0] ld_val;
    logic [DATA_W-1:0] wb_val;
    logic [DATA_W-1:0] immv;
    logic [DATA_W-1:0] rs_q, rt_q, rd_q;
    logic [DATA_W-1:0] op_a, op_b, op_d;
    rf_wr_t            rf_wr;
    dmem_req_t         dm_req;
    out_item_t         ex_res;
    exec_ctl_t         ex_ctl;

    // operand select: r0, r1 (immediate), newest writer, write that landed with the
    // read, then the registered file data
    function automatic logic [DATA_W-1:0] pick_operand(
        input logic [REG_AW-1:0] idx,
        input logic [DATA_W-1:0] q,
        input logic [DATA_W-1:0] imm,
        input wb_info_t          last,
        input logic [DATA_W-1:0] last_val,
        input logic              cap_v,
        input logic [REG_AW-1:0] cap_n,
        input logic [DATA_W-1:0] cap_d
    );
        logic [DATA_W-1:0] r;
        if (idx == REG_ZERO) begin
            r = '0;
        end else if (idx == REG_IMM) begin
            r = imm;
        end else if (last.wr && last.num == idx) begin
            r = last_val;
        end else if (cap_v && cap_n == idx) begin
            r = cap_d;
        end else begin
            r = q;
        end
        return r;
    endfunction

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !dm_busy && (!s1_valid_reg || s1_adv);
    assign accept  = s_valid && s_ready;

    assign ld_val = sext_word(dm_rdata);
    assign wb_val = last_wr_reg.load ? ld_val : last_wr_reg.val;
    assign immv   = s1_item_reg.has_immediate ? sext_word(s1_item_reg.immediate) : '0;

    assign rf_wr.en   = wb_pending_reg;
    assign rf_wr.num  = last_wr_reg.num;
    assign rf_wr.data = wb_val;

    rie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rs_addr (s_payload.src_a_index),
        .rt_addr (s_payload.src_b_index),
        .rd_addr (s_payload.dest_index),
        .wr      (rf_wr),
        .rs_data (rs_q),
        .rt_data (rt_q),
        .rd_data (rd_q)
    );

    assign op_a = pick_operand(s1_item_reg.src_a_index, rs_q, immv, last_wr_reg, wb_val,
                               cap_valid_reg, cap_num_reg, cap_val_reg);
    assign op_b = pick_operand(s1_item_reg.src_b_index, rt_q, immv, last_wr_reg, wb_val,
                               cap_valid_reg, cap_num_reg, cap_val_reg);
    assign op_d = pick_operand(s1_item_reg.dest_index, rd_q, immv, last_wr_reg, wb_val,
                               cap_valid_reg, cap_num_reg, cap_val_reg);

    rie_exec u_exec (
        .item      (s1_item_reg),
        .a         (op_a),
        .b         (op_b),
        .d         (op_d),
        .pc        (pc_reg),
        .halted_in (halt_reg),
        .io_regs   (io_reg),
        .result    (ex_res),
        .ctl       (ex_ctl)
    );

    assign dm_req.we    = s1_adv && ex_ctl.store;
    assign dm_req.re    = s1_adv && ex_ctl.load;
    assign dm_req.addr  = ex_ctl.mem_addr;
    assign dm_req.wdata = ex_ctl.mem_wdata;

    rie_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dm_req),
        .rdata   (dm_rdata),
        .busy    (dm_busy)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_payload;
        end
    end

    // architectural state, result register and write-back tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pc_reg         <= '0;
            halt_reg       <= 1'b0;
            io_reg         <= '0;
            last_wr_reg    <= '0;
            wb_pending_reg <= 1'b0;
            cap_valid_reg  <= 1'b0;
        end else begin
            // the write landing with this read is invisible to the read data
            if (accept) begin
                cap_valid_reg <= wb_pending_reg;
            end
            if (s1_adv) begin
                m_valid_reg      <= 1'b1;
                pc_reg           <= ex_res.next_pc;
                halt_reg         <= ex_res.halted;
                last_wr_reg.wr   <= ex_res.reg_written;
                last_wr_reg.num  <= ex_res.reg_number;
                last_wr_reg.val  <= ex_res.reg_value;
                last_wr_reg.load <= ex_ctl.load;
                wb_pending_reg   <= ex_res.reg_written;
                if (ex_res.io_written) begin
                    io_reg[ex_ctl.io_idx] <= ex_res.io_value;
                end
            end else begin
                wb_pending_reg <= 1'b0;
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cap_num_reg <= last_wr_reg.num;
            cap_val_reg <= wb_val;
        end
        if (s1_adv) begin
            out_reg      <= ex_res;
            out_load_reg <= ex_ctl.load && ex_res.reg_written;
        end
    end

    always_comb begin
        m_payload = out_reg;
        if (out_load_reg) begin
            m_payload.reg_value = ld_val;
        end
    end

    assign m_valid = m_valid_reg;

    `RIE_ASSERT_IMP(a_no_beat_in_clear, dm_busy, !s_ready, "beat taken during memory clear")
    `RIE_ASSERT_IMP(a_wb_in_result_stage, wb_pending_reg, m_valid_reg,
                    "register write-back with no result held")
    `RIE_ASSERT_IMP(a_halted_no_effect, s1_adv && halt_reg,
                    !ex_ctl.store && !ex_res.io_written && !ex_res.reg_written,
                    "state written after halt")
    `RIE_ASSERT_NXT(a_halted_pc_held, halt_reg, halt_reg && pc_reg == $past(pc_reg),
                    "pc or halt flag moved after halt")

endmodule

// ===== sim/risc_instruction_execute_tb.sv =====
// Self-checking testbench for risc_instruction_execute: directed and random instruction
// beats, with a scoreboard class that predicts each result. Needs rie_pkg and the RTL.
`timescale 1ns / 100ps

module risc_instruction_execute_tb import rie_pkg::*; ();

    // reset sweeps the data memory before any beat is taken; this limit stays well clear of that sweep
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_INSTRS = 1500;
    localparam int AFTER_HALT = 24;

    class execute_checker;
        logic [DATA_W-1:0] regs [REG_COUNT];
        logic [WORD_W-1:0] dmem [MEM_DEPTH];
        logic [DATA_W-1:0] io_regs [IO_COUNT];
        logic [PC_W-1:0]   pc;
        bit                stopped;
        out_item_t         pending_results [$];
        int unsigned       errors;
        int unsigned       instr_count;
        int unsigned       result_count;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            foreach (io_regs[i]) io_regs[i] = '0;
            pc = '0;
            stopped = 1'b0;
            errors = 0;
            instr_count = 0;
            result_count = 0;
        endfunction

        function logic [DATA_W-1:0] operand(logic [REG_AW-1:0] idx, logic [DATA_W-1:0] immv);
            if (idx == REG_ZERO) return '0;
            if (idx == REG_IMM) return immv;
            return regs[idx];
        endfunction

        function out_item_t run_instruction(in_item_t it);
            out_item_t         r;
            logic [DATA_W-1:0] immv, a, b, d, val, sum;
            logic [PC_W-1:0]   npc;
            logic [4:0]        sh;
            logic [MEM_ADDR_W-1:0] maddr;
            logic [IO_NUM_W-1:0]   ionum;
            bit                wr;
            r = '0;
            if (stopped) begin
                r.next_pc = pc;
                r.halted = 1'b1;
                return r;
            end
            immv = it.has_immediate ? {{(DATA_W - WORD_W){it.immediate[WORD_W-1]}},
                                       it.immediate} : '0;
            a = operand(it.src_a_index, immv);
            b = operand(it.src_b_index, immv);
            d = operand(it.dest_index, immv);
            sh = b[4:0];
            sum = a + b;
            maddr = MEM_ADDR_W'(sum % MEM_DEPTH);
            ionum = IO_NUM_W'(sum % IO_COUNT);
            npc = pc + PC_W'(1) + PC_W'(it.has_immediate);
            val = '0;
            wr = 1'b0;
            case (it.op)
                OP_ADD: begin val = a + b; wr = 1'b1; end
                OP_SUB: begin val = a - b; wr = 1'b1; end
                OP_MUL: begin val = a * b; wr = 1'b1; end
                OP_AND: begin val = a & b; wr = 1'b1; end
                OP_OR:  begin val = a | b; wr = 1'b1; end
                OP_XOR: begin val = a ^ b; wr = 1'b1; end
                OP_SLL: begin val = a << sh; wr = 1'b1; end
                OP_SRA: begin val = $signed(a) >>> sh; wr = 1'b1; end
                OP_SRL: begin val = a >> sh; wr = 1'b1; end
                OP_BEQ: if (a == b) npc = d[PC_W-1:0];
                OP_BNE: if (a != b) npc = d[PC_W-1:0];
                OP_BLT: if ($signed(a) < $signed(b)) npc = d[PC_W-1:0];
                OP_BGT: if ($signed(a) > $signed(b)) npc = d[PC_W-1:0];
                OP_BLE: if ($signed(a) <= $signed(b)) npc = d[PC_W-1:0];
                OP_BGE: if ($signed(a) >= $signed(b)) npc = d[PC_W-1:0];
                OP_JAL: begin
                    // link gets the advanced pc; target was read before the write
                    val = DATA_W'(npc);
                    wr = 1'b1;
                    npc = a[PC_W-1:0];
                end
                OP_LW: begin
                    r.mem_address = maddr;
                    val = {{(DATA_W - WORD_W){dmem[maddr][WORD_W-1]}}, dmem[maddr]};
                    wr = 1'b1;
                end
                OP_SW: begin
                    r.mem_address = maddr;
                    r.mem_written = 1'b1;
                    dmem[maddr] = d[WORD_W-1:0];
                end
                OP_RETI: npc = io_regs[IRQ_SLOT][PC_W-1:0];
                OP_IN: begin
                    r.io_number = ionum;
                    r.io_value = io_regs[ionum];
                    val = io_regs[ionum];
                    wr = 1'b1;
                end
                OP_OUT: begin
                    r.io_number = ionum;
                    r.io_value = d;
                    r.io_written = 1'b1;
                    io_regs[ionum] = d;
                end
                OP_HALT: begin
                    npc = pc;
                    stopped = 1'b1;
                end
                default: begin
                    npc = pc;
                    stopped = 1'b1;
                    r.bad_opcode = 1'b1;
                end
            endcase
            if (wr && it.dest_index >= FIRST_GPR) begin
                regs[it.dest_index] = val;
                r.reg_written = 1'b1;
                r.reg_number = it.dest_index;
                r.reg_value = val;
            end
            pc = npc;
            r.next_pc = pc;
            r.halted = stopped;
            return r;
        endfunction

        function void note_instruction(in_item_t it);
            instr_count++;
            pending_results.push_back(run_instruction(it));
        endfunction

        function void show(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (want !== got) $display("    %s expected %h got %h", name, want, got);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            result_count++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result beat %0d arrived with nothing pending: %p",
                                           result_count, got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("result beat %0d differs:", result_count);
                    show("next_pc", want.next_pc, got.next_pc);
                    show("reg_written", want.reg_written, got.reg_written);
                    show("reg_number", want.reg_number, got.reg_number);
                    show("reg_value", want.reg_value, got.reg_value);
                    show("mem_written", want.mem_written, got.mem_written);
                    show("mem_address", want.mem_address, got.mem_address);
                    show("io_written", want.io_written, got.io_written);
                    show("io_number", want.io_number, got.io_number);
                    show("io_value", want.io_value, got.io_value);
                    show("halted", want.halted, got.halted);
                    show("bad_opcode", want.bad_opcode, got.bad_opcode);
                end
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_payload;

    execute_checker sb = new();
    int unsigned    quiet_cycles = 0;
    bit             calm = 1'b0;

    risc_instruction_execute u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready) sb.note_instruction(s_payload);
        if (m_valid && m_ready) sb.check_result(m_payload);
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("risc_instruction_execute_tb NOT OK");
        $finish;
    end

    // result side: random stalls, one long hold-off once the pipe has seen some traffic
    initial begin : sink
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && sb.instr_count >= 300) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
        end
    end

    function automatic in_item_t instr(logic [4:0] op, int rd, int rs, int rt,
                                       int imm = 0, bit has = 1'b0);
        in_item_t it;
        it.op = op;
        it.dest_index = REG_AW'(rd);
        it.src_a_index = REG_AW'(rs);
        it.src_b_index = REG_AW'(rt);
        it.immediate = WORD_W'(imm);
        it.has_immediate = has;
        return it;
    endfunction

    function automatic in_item_t random_instr();
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      it.op = 5'($urandom_range(OP_ADD, OP_SRL));
        else if (pick < 63) it.op = 5'($urandom_range(OP_BEQ, OP_BGE));
        else if (pick < 68) it.op = OP_JAL;
        else if (pick < 82) it.op = 5'($urandom_range(OP_LW, OP_SW));
        else if (pick < 85) it.op = OP_RETI;
        else                it.op = 5'($urandom_range(OP_IN, OP_OUT));
        it.dest_index = REG_AW'($urandom_range(0, 15));
        it.src_a_index = REG_AW'($urandom_range(0, 15));
        it.src_b_index = REG_AW'($urandom_range(0, 15));
        it.has_immediate = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 15))
            0:       it.immediate = {1'b1, {(WORD_W - 1){1'b0}}};
            1:       it.immediate = {1'b0, {(WORD_W - 1){1'b1}}};
            2:       it.immediate = '1;
            3:       it.immediate = '0;
            default: it.immediate = WORD_W'($urandom);
        endcase
        // half the memory and I/O beats use an immediate address so that words get reused
        if (((it.op >= OP_LW && it.op <= OP_SW) || (it.op >= OP_IN && it.op <= OP_OUT))
            && $urandom_range(0, 1) != 0) begin
            it.src_a_index = REG_IMM;
            it.src_b_index = REG_ZERO;
            it.has_immediate = 1'b1;
            it.immediate = WORD_W'($urandom_range(0, 63));
        end
        return it;
    endfunction

    task automatic send_instr(in_item_t it);
        int gap;
        gap = 0;
        if (!calm) while ($urandom_range(0, 99) < 35) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin : stimulus
        in_item_t   directed [$];
        in_item_t   it;
        logic [4:0] stop_op;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_payload <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // field extremes, every operation but halt, zero/immediate registers
        directed.push_back(instr(OP_ADD, 2, 1, 0, 524287, 1'b1));
        directed.push_back(instr(OP_ADD, 3, 1, 0, -524288, 1'b1));
        directed.push_back(instr(OP_MUL, 4, 2, 3));
        directed.push_back(instr(OP_SUB, 5, 3, 2));
        directed.push_back(instr(OP_SLL, 6, 2, 1, 31, 1'b1));
        directed.push_back(instr(OP_SRA, 7, 6, 1, 31, 1'b1));
        directed.push_back(instr(OP_SRL, 8, 6, 1, 31, 1'b1));
        directed.push_back(instr(OP_SLL, 9, 3, 0));
        directed.push_back(instr(OP_AND, 10, 3, 4));
        directed.push_back(instr(OP_OR, 11, 3, 4));
        directed.push_back(instr(OP_XOR, 12, 3, 4));
        directed.push_back(instr(OP_BEQ, 1, 2, 2, 'hABC, 1'b1));
        directed.push_back(instr(OP_BNE, 1, 2, 2, 5, 1'b1));
        directed.push_back(instr(OP_BLT, 7, 3, 2));
        directed.push_back(instr(OP_BGT, 2, 3, 2));
        directed.push_back(instr(OP_BLE, 2, 2, 2));
        directed.push_back(instr(OP_BGE, 1, 6, 0, 9, 1'b1));
        // link register equal to target register: jumps to the old value
        directed.push_back(instr(OP_JAL, 5, 5, 0));
        directed.push_back(instr(OP_SW, 3, 1, 0, MEM_DEPTH - 1, 1'b1));
        directed.push_back(instr(OP_LW, 13, 1, 0, MEM_DEPTH - 1, 1'b1));
        directed.push_back(instr(OP_LW, 14, 15, 15));
        directed.push_back(instr(OP_OUT, 7, 1, 0, IRQ_RETURN_INDEX, 1'b1));
        directed.push_back(instr(OP_RETI, 0, 0, 0));
        // in to register zero still reports the value read
        directed.push_back(instr(OP_IN, 0, 1, 0, IRQ_RETURN_INDEX, 1'b1));
        directed.push_back(instr(OP_ADD, 1, 2, 2));
        directed.push_back(instr(OP_IN, 15, 2, 3));
        foreach (directed[i]) send_instr(directed[i]);

        for (int n = 0; n < RANDOM_INSTRS; n++) begin
            calm = (n >= 500 && n < 800);
            send_instr(random_instr());
        end
        calm = 1'b0;

        // halting is permanent, so it closes the run, followed by beats that must be ignored
        if ($urandom_range(0, 1) != 0) stop_op = OP_HALT;
        else stop_op = 5'($urandom_range(OP_HALT + 1, 31));
        it = random_instr();
        it.op = stop_op;
        send_instr(it);
        for (int n = 0; n < AFTER_HALT; n++) begin
            it = random_instr();
            it.op = 5'($urandom_range(0, 31));
            send_instr(it);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("risc_instruction_execute_tb OK");
        end else begin
            $display("risc_instruction_execute_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== risc_instruction_execute.f =====
+incdir+hw/rtl
hw/rtl/rie_pkg.sv
hw/rtl/rie_regfile.sv
hw/rtl/rie_dmem.sv
hw/rtl/rie_exec.sv
hw/rtl/risc_instruction_execute.sv
sim/risc_instruction_execute_tb.sv
